### sv/assert_macros.svh
// Assertion macros used by the checker file of the strip dedup labeler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SDL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sdl assertion failed");

// Clocked assertion that also holds during reset.
`define SDL_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("sdl assertion failed");

`endif

### sv/sdl_pkg.sv
// Types, constants and codes shared by the strip dedup labeler modules.
package sdl_pkg;

   // Dictionary geometry.
   localparam int MAX_STRIPS      = 256;
   localparam int MAX_STRIP_UNITS = 32;
   localparam int STORE_DEPTH     = MAX_STRIPS * MAX_STRIP_UNITS;
   localparam int STORE_ADDR_W    = $clog2(STORE_DEPTH);
   localparam int IDX_W           = $clog2(MAX_STRIPS);
   localparam int CNT_W           = $clog2(MAX_STRIPS + 1);
   localparam int POS_W           = (MAX_STRIP_UNITS > 1) ? $clog2(MAX_STRIP_UNITS) : 1;
   localparam int LEN_EFF_W       = $clog2(MAX_STRIP_UNITS + 1);

   // Field widths of the transactions.
   localparam int UNIT_W   = 8;
   localparam int LEN_W    = 6;
   localparam int LABEL_W  = 8;
   localparam int COUNT_W  = 9;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_STRIP_LENGTH = 1'b0;
   localparam logic [LEN_W-1:0] STRIP_LENGTH_RESET = LEN_W'(32);

   typedef struct packed {
      logic [UNIT_W-1:0] unit_value;
      logic              first_of_set;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] strip_label;
      logic               is_new;
      logic               table_full;
      logic [COUNT_W-1:0] distinct_count;
   } rsp_type;

   // Control of the match cell row.
   typedef struct packed {
      logic set_all;
      logic shift;
      logic feed_bit;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

### sv/strip_dedup_labeler_unit.sv
// Top level of the strip dedup labeler: sequencer, register port and result register.
//
// Source units enter on the req_ channel (valid/stall), one byte per transaction, and
// are cut into strips of strip_length units (register 0 of the csr port, reset 32).
// Each unit is compared with the same position of every stored strip while it is
// written into the next free slot. When a strip completes, one transaction leaves on
// the rsp_ channel with the label of the first matching stored strip, or the next
// label if the strip is new, or table_full with label zero when the table is full.
// A unit with first_of_set empties the dictionary first. For each unit the
// single-port store is read once per stored entry, at stride strip_length, and the
// match vector rotates one cell per read through the row of match cells. A new unit
// is taken only once the previous one is finished.
// The result sits in an output register; while the receiver stalls, the block keeps
// taking units and only waits when the next strip completes with the register full.
// Synchronous reset empties the dictionary, sets the strip length to 32 and drops
// any pending result. The store itself is not cleared.
module strip_dedup_labeler_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Unit input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sdl_pkg::req_type                   req_data,
   // Result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sdl_pkg::rsp_type                   rsp_data,
   // Register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sdl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [sdl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [sdl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   import sdl_pkg::*;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]        strip_length_ff, strip_length_in;
   logic [UNIT_W-1:0]       unit_ff, unit_in;
   logic [LEN_EFF_W-1:0]    len_ff, len_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        e_ff, e_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [STORE_ADDR_W-1:0] addr_ff, addr_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        label_ff, label_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    csr_write;
   logic                    rd_en;
   logic                    wr_en;
   logic                    strip_done;
   logic                    out_free;
   logic                    finish_go;
   logic                    head_bit;
   logic                    cmp_bit;
   logic [UNIT_W-1:0]       rd_data;
   logic [LEN_EFF_W-1:0]    len_eff;
   logic [POS_W:0]          pos_inc;
   logic [CNT_W-1:0]        cnt_start;
   logic [POS_W-1:0]        pos_start;
   chain_ctrl_type          chain_ctrl;

   // Register port: always ready, one register at word 0.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_STRIP_LENGTH);
   assign prdata    = (paddr[2] == REG_STRIP_LENGTH) ?
                      CSR_DATA_W'(strip_length_ff) : '0;
   assign strip_length_in = csr_write ? pwdata[LEN_W-1:0] : strip_length_ff;

   // Effective strip length: zero counts as one, oversize saturates.
   always_comb begin
      if (strip_length_ff == '0) begin
         len_eff = LEN_EFF_W'(1);
      end else if (int'(strip_length_ff) > MAX_STRIP_UNITS) begin
         len_eff = LEN_EFF_W'(MAX_STRIP_UNITS);
      end else begin
         len_eff = LEN_EFF_W'(strip_length_ff);
      end
   end

   // Handshake and status terms.
   assign accept     = req_valid && !req_stall;
   assign pos_inc    = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign strip_done = pos_inc >= (POS_W + 1)'(len_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cnt_start  = req_data.first_of_set ? '0 : cnt_ff;
   assign pos_start  = req_data.first_of_set ? '0 : pos_ff;
   assign cmp_bit    = head_bit && (rd_data == unit_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (e_ff == cnt_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!strip_done || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SWEEP: begin
            rd_en = e_ff != cnt_ff;
            wr_en = (e_ff == cnt_ff) && (int'(cnt_ff) < MAX_STRIPS);
         end
         ST_FINISH: begin
            finish_go = strip_done && out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Match row control: rotate on each compare, refill at a new set or a new strip.
   always_comb begin
      chain_ctrl.set_all  = (accept && req_data.first_of_set) || finish_go;
      chain_ctrl.shift    = rd_pend_ff;
      chain_ctrl.feed_bit = cmp_bit;
   end

   // Datapath next values.
   always_comb begin
      unit_in      = unit_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      e_in         = e_ff;
      k_in         = k_ff;
      addr_in      = addr_ff;
      found_in     = found_ff;
      label_in     = label_ff;
      rd_pend_in   = rd_en;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // A new unit starts a sweep over the stored entries.
      if (accept) begin
         unit_in  = req_data.unit_value;
         len_in   = len_eff;
         pos_in   = pos_start;
         cnt_in   = cnt_start;
         e_in     = '0;
         k_in     = '0;
         addr_in  = STORE_ADDR_W'(pos_start);
         found_in = 1'b0;
      end

      // Each read steps to the same position of the next entry.
      if (rd_en) begin
         e_in    = e_ff + CNT_W'(1);
         addr_in = addr_ff + STORE_ADDR_W'(len_ff);
      end

      // Compares arrive in entry order, so the first survivor is the label.
      if (rd_pend_ff) begin
         k_in = k_ff + CNT_W'(1);
         if (cmp_bit && !found_ff) begin
            found_in = 1'b1;
            label_in = IDX_W'(k_ff);
         end
      end

      // End of one unit: advance the position or close the strip.
      if (state_ff == ST_FINISH && !strip_done) begin
         pos_in = POS_W'(pos_inc);
      end
      if (finish_go) begin
         pos_in       = '0;
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            rsp_data_in.strip_label    = LABEL_W'(label_ff);
            rsp_data_in.is_new         = 1'b0;
            rsp_data_in.table_full     = 1'b0;
            rsp_data_in.distinct_count = COUNT_W'(cnt_ff);
         end else if (int'(cnt_ff) < MAX_STRIPS) begin
            cnt_in                     = cnt_ff + CNT_W'(1);
            rsp_data_in.strip_label    = LABEL_W'(cnt_ff);
            rsp_data_in.is_new         = 1'b1;
            rsp_data_in.table_full     = 1'b0;
            rsp_data_in.distinct_count = COUNT_W'(cnt_ff + CNT_W'(1));
         end else begin
            rsp_data_in.strip_label    = '0;
            rsp_data_in.is_new         = 1'b0;
            rsp_data_in.table_full     = 1'b1;
            rsp_data_in.distinct_count = COUNT_W'(cnt_ff);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         strip_length_ff <= STRIP_LENGTH_RESET;
         pos_ff          <= '0;
         cnt_ff          <= '0;
         e_ff            <= '0;
         k_ff            <= '0;
         rd_pend_ff      <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         strip_length_ff <= strip_length_in;
         pos_ff          <= pos_in;
         cnt_ff          <= cnt_in;
         e_ff            <= e_in;
         k_ff            <= k_in;
         rd_pend_ff      <= rd_pend_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      unit_ff     <= unit_in;
      len_ff      <= len_in;
      addr_ff     <= addr_in;
      label_ff    <= label_in;
      rsp_data_ff <= rsp_data_in;
   end

   sdl_dict_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (rd_en),
      .addr    (addr_ff),
      .wr_data (unit_ff),
      .rd_data (rd_data)
   );

   sdl_match_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (chain_ctrl),
      .entry_count (cnt_ff),
      .head_bit    (head_bit)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/sdl_match_cell.sv
// One match cell: holds the match bit of one dictionary entry.
module sdl_match_cell (
   input  logic clock,
   input  logic reset,
   input  logic set_all,
   input  logic shift,
   input  logic active,
   input  logic tail,
   input  logic neighbor_bit,
   input  logic feed_bit,
   output logic match_bit
);

   logic match_ff;
   logic match_in;

   // Active cells pass their bit toward the head; the tail cell takes the updated bit.
   always_comb begin
      match_in = match_ff;
      if (set_all) begin
         match_in = 1'b1;
      end else if (shift && active) begin
         match_in = tail ? feed_bit : neighbor_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b1;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match_bit = match_ff;

endmodule

### sv/sdl_match_chain.sv
// Row of match cells that circulates the match vector past the compare point.
module sdl_match_chain (
   input  logic                          clock,
   input  logic                          reset,
   input  sdl_pkg::chain_ctrl_type       ctrl,
   input  logic [sdl_pkg::CNT_W-1:0]     entry_count,
   output logic                          head_bit
);

   import sdl_pkg::*;

   logic [MAX_STRIPS-1:0] bits;

   // The loop closes at the last stored entry, so one lap takes entry_count shifts.
   for (genvar i = 0; i < MAX_STRIPS; i++) begin : g_cell
      logic active;
      logic tail;
      logic neighbor;

      assign active = CNT_W'(i) < entry_count;
      assign tail   = CNT_W'(i + 1) == entry_count;

      if (i == MAX_STRIPS - 1) begin : g_last
         assign neighbor = 1'b1;
      end else begin : g_inner
         assign neighbor = bits[i + 1];
      end

      sdl_match_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .set_all      (ctrl.set_all),
         .shift        (ctrl.shift),
         .active       (active),
         .tail         (tail),
         .neighbor_bit (neighbor),
         .feed_bit     (ctrl.feed_bit),
         .match_bit    (bits[i])
      );
   end

   assign head_bit = bits[0];

endmodule

### sv/sdl_dict_store.sv
// Single-port dictionary store of strip units with a registered read.
module sdl_dict_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic                             rd_en,
   input  logic [sdl_pkg::STORE_ADDR_W-1:0] addr,
   input  logic [sdl_pkg::UNIT_W-1:0]       wr_data,
   output logic [sdl_pkg::UNIT_W-1:0]       rd_data
);

   import sdl_pkg::*;

   logic [UNIT_W-1:0] mem [STORE_DEPTH];
   logic [UNIT_W-1:0] rd_data_ff;

   // A write, a read, or both, on the one shared address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sdl_checker.sv
// Port-level checker for the strip dedup labeler and its bind.
`include "assert_macros.svh"

module sdl_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sdl_pkg::rsp_type rsp_data
);

   import sdl_pkg::*;

   // No result survives a reset.
   `SDL_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   // A stalled result transaction holds.
   `SDL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // A full table gives label zero and keeps the count at capacity.
   `SDL_ASSERT(a_full_result, clock, reset, rsp_valid && rsp_data.table_full |-> !rsp_data.is_new && rsp_data.strip_label == '0 && int'(rsp_data.distinct_count) == MAX_STRIPS)

   // A new strip takes the next label, so the count is its label plus one.
   `SDL_ASSERT(a_new_label, clock, reset, rsp_valid && rsp_data.is_new |-> rsp_data.distinct_count == ({1'b0, rsp_data.strip_label} + COUNT_W'(1)))

   // A matched strip names an entry that already exists.
   `SDL_ASSERT(a_match_label, clock, reset, rsp_valid && !rsp_data.is_new && !rsp_data.table_full |-> {1'b0, rsp_data.strip_label} < rsp_data.distinct_count)

endmodule

bind strip_dedup_labeler_unit sdl_checker u_sdl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/sv/strip_dedup_labeler_unit_tb.sv
// Self-checking testbench of the strip dedup labeler: directed and random unit streams.
module strip_dedup_labeler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdl_pkg::*;

   // Run shape.
   localparam int unsigned HOLD_CYCLES   = 2000;
   localparam int unsigned SETTLE_CYCLES = MAX_STRIPS + 44;
   localparam int unsigned STALL_LIMIT   = 20000;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_UNITS   = 101;
   localparam logic [CSR_ADDR_W-1:0] STRIP_LENGTH_ADDR = CSR_ADDR_W'(4 * REG_STRIP_LENGTH);

   // Idle patterns of the two channels.
   typedef enum int {
      FLOW_FREE,
      FLOW_SRC_GAPS,
      FLOW_SINK_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   strip_dedup_labeler_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Stimulus and expectation stores.
   req_type       pend_units [$];
   rsp_type       expected_labels [$];
   rsp_type       head_label;
   flow_mode_type flow_mode       = FLOW_FREE;
   bit            long_hold_armed = 1'b0;
   int unsigned   hold_count      = 0;
   bit            unit_taken      = 1'b0;
   int unsigned   quiet_cycles    = 0;

   // Tallies.
   int unsigned units_in      = 0;
   int unsigned results_seen  = 0;
   int unsigned fresh_seen    = 0;
   int unsigned full_seen     = 0;
   int unsigned fault_count   = 0;

   // Shadow dictionary of the labeler.
   logic [UNIT_W-1:0]     dict_store [STORE_DEPTH];
   logic [MAX_STRIPS-1:0] dict_match = '1;
   int unsigned           dict_count = 0;
   logic [POS_W-1:0]      dict_pos   = '0;
   logic [LEN_W-1:0]      dict_len   = STRIP_LENGTH_RESET;

   function automatic bit coin(int unsigned pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   function automatic int unsigned idle_pct(flow_mode_type mode, bit sink_side);
      case (mode)
         FLOW_SRC_GAPS:    return sink_side ? 0 : 61;
         FLOW_SINK_STALLS: return sink_side ? 61 : 0;
         FLOW_BOTH:        return 36;
         default:          return 0;
      endcase
   endfunction

   // Zero counts as one unit and oversize lengths saturate.
   function automatic int unsigned strip_span(logic [LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > MAX_STRIP_UNITS) return MAX_STRIP_UNITS;
      return 32'(len);
   endfunction

   // Take one unit into the shadow dictionary; queue the label when a strip completes.
   task automatic absorb_unit(req_type src);
      int unsigned span;
      int unsigned pos;
      int unsigned hit;
      bit          found;
      rsp_type     outcome;
      span = strip_span(dict_len);
      if (src.first_of_set) begin
         dict_match = '1;
         dict_count = 0;
         dict_pos   = '0;
      end
      pos = 32'(dict_pos);
      // Strike every stored strip that differs at this position.
      for (int unsigned e = 0; e < dict_count; e++) begin
         if (dict_store[e * span + pos] != src.unit_value) dict_match[e] = 1'b0;
      end
      if (dict_count < MAX_STRIPS) dict_store[dict_count * span + pos] = src.unit_value;
      if (pos + 1 < span) begin
         dict_pos = POS_W'(pos + 1);
         return;
      end
      // Strip complete: first survivor wins, else store it under the next label.
      found = 1'b0;
      hit   = 0;
      for (int unsigned e = 0; e < dict_count; e++) begin
         if (!found && dict_match[e]) begin
            hit   = e;
            found = 1'b1;
         end
      end
      outcome = '0;
      if (found) begin
         outcome.strip_label = LABEL_W'(hit);
      end else if (dict_count < MAX_STRIPS) begin
         outcome.strip_label = LABEL_W'(dict_count);
         outcome.is_new      = 1'b1;
         dict_count++;
      end else begin
         outcome.table_full = 1'b1;
      end
      outcome.distinct_count = COUNT_W'(dict_count);
      dict_match = '1;
      dict_pos   = '0;
      expected_labels.push_back(outcome);
   endtask

   task automatic flag_field(string field, int unsigned want, int unsigned got);
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fault_count++;
   endtask

   // Driver: presents the next pending unit, holding it until the transaction completes.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !unit_taken) begin
         req_valid <= 1'b1;
      end else if (pend_units.size() > 0 && !coin(idle_pct(flow_mode, 1'b0))) begin
         req_valid <= 1'b1;
         req_data  <= pend_units[0];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stalls, plus one long hold-off to back the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= coin(idle_pct(flow_mode, 1'b1));
      end
   end

   // Monitor: predicts from accepted units and checks each accepted result.
   always @(posedge clock) begin
      unit_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            absorb_unit(req_data);
            void'(pend_units.pop_front());
            unit_taken = 1'b1;
            units_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_labels.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual label 0x%0h",
                        $time, rsp_data.strip_label);
               fault_count++;
            end else begin
               head_label = expected_labels.pop_front();
               if (head_label.is_new) fresh_seen++;
               if (head_label.table_full) full_seen++;
               if (rsp_data.strip_label !== head_label.strip_label)
                  flag_field("strip_label", 32'(head_label.strip_label),
                             32'(rsp_data.strip_label));
               if (rsp_data.is_new !== head_label.is_new)
                  flag_field("is_new", 32'(head_label.is_new), 32'(rsp_data.is_new));
               if (rsp_data.table_full !== head_label.table_full)
                  flag_field("table_full", 32'(head_label.table_full),
                             32'(rsp_data.table_full));
               if (rsp_data.distinct_count !== head_label.distinct_count)
                  flag_field("distinct_count", 32'(head_label.distinct_count),
                             32'(rsp_data.distinct_count));
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_labels.size());
            $display("FAIL strip_dedup_labeler_unit");
            $finish;
         end
      end
   end

   task automatic queue_unit(logic [UNIT_W-1:0] value, bit fos);
      req_type src;
      src.unit_value   = value;
      src.first_of_set = fos;
      pend_units.push_back(src);
   endtask

   // Wait for all units and results, then give the block time to finish sweeping the last unit.
   task automatic wait_until_idle();
      while (pend_units.size() != 0 || expected_labels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register transfer: setup cycle, then access cycle until pready.
   task automatic csr_cycle(bit is_write, logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= STRIP_LENGTH_ADDR;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Change the strip length while idle and read it back; junk in the upper bits is dropped.
   task automatic set_strip_length(logic [LEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] readback;
      wait_until_idle();
      csr_cycle(1'b1, (CSR_DATA_W'($urandom()) & ~CSR_DATA_W'(6'h3F)) | CSR_DATA_W'(len),
                readback);
      dict_len = len;
      csr_cycle(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(len))
         flag_field("strip_length readback", 32'(len), readback);
   endtask

   // Random sets: mostly strips replayed from the current set or drawn from a small
   // alphabet, with some full-range bytes, stray set starts and corrupted units.
   task automatic queue_random_units(int unsigned count, bit open_set);
      logic [UNIT_W-1:0]              pool [4];
      logic [8*MAX_STRIP_UNITS-1:0]   strip_bits;
      logic [8*MAX_STRIP_UNITS-1:0]   strip_book [$];
      logic [UNIT_W-1:0]              value;
      int unsigned                    span;
      int unsigned                    made;
      bit                             fresh_set;
      bit                             fos;
      span      = strip_span(dict_len);
      made      = 0;
      fresh_set = open_set;
      foreach (pool[i]) pool[i] = UNIT_W'($urandom_range(255, 0));
      while (made < count) begin
         if (coin(5)) fresh_set = 1'b1;
         if (fresh_set) begin
            strip_book.delete();
            foreach (pool[i]) pool[i] = UNIT_W'($urandom_range(255, 0));
         end
         if (strip_book.size() > 0 && coin(45)) begin
            strip_bits = strip_book[$urandom_range(strip_book.size() - 1, 0)];
         end else begin
            strip_bits = '0;
            for (int unsigned k = 0; k < span; k++) begin
               strip_bits[8*k +: 8] = coin(75) ? pool[$urandom_range(3, 0)]
                                                : UNIT_W'($urandom_range(255, 0));
            end
            strip_book.push_back(strip_bits);
         end
         // A phase may end inside a strip, so the next length takes over mid-strip.
         for (int unsigned k = 0; k < span && made < count; k++) begin
            value = strip_bits[8*k +: 8];
            fos   = (k == 0 && fresh_set) || coin(1);
            if (coin(2)) value = UNIT_W'($urandom_range(255, 0));
            queue_unit(value, fos);
            made++;
         end
         fresh_set = 1'b0;
      end
   endtask

   // Sequence of the run.
   initial begin
      int unsigned           phase_len [RANDOM_PHASES];
      logic [CSR_DATA_W-1:0] readback;
      bit                    grow;
      phase_len    = '{1, 2, 32, 0, 5, 63, 3, 40, 4, 6, 2, 1};
      phase_len[9] = $urandom_range(MAX_STRIP_UNITS, 1);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_cycle(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(STRIP_LENGTH_RESET))
         flag_field("strip_length after reset", 32'(STRIP_LENGTH_RESET), readback);

      // Length zero acts as one unit: extremes of the byte, a repeat and a new entry.
      set_strip_length(6'd0);
      queue_unit(8'h00, 1'b1);
      queue_unit(8'hFF, 1'b0);
      queue_unit(8'h00, 1'b0);
      queue_unit(8'hA5, 1'b0);

      // Three-unit strips: new, repeat, near miss, then stop inside a strip.
      set_strip_length(6'd3);
      queue_unit(8'h01, 1'b1);
      queue_unit(8'h02, 1'b0);
      queue_unit(8'h03, 1'b0);
      queue_unit(8'h01, 1'b0);
      queue_unit(8'h02, 1'b0);
      queue_unit(8'h03, 1'b0);
      queue_unit(8'h01, 1'b0);
      queue_unit(8'h02, 1'b0);
      queue_unit(8'h04, 1'b0);
      queue_unit(8'h01, 1'b0);
      queue_unit(8'h02, 1'b0);

      // Shorter length inside the set: the pending strip completes with its next unit.
      set_strip_length(6'd2);
      queue_unit(8'h03, 1'b0);
      queue_unit(8'h80, 1'b0);
      queue_unit(8'h7F, 1'b0);

      // Oversize length saturates; a new set starts since the layout grows.
      set_strip_length(6'd63);
      queue_unit(8'hAA, 1'b1);
      queue_unit(8'h55, 1'b0);

      // Fill all entries with two-unit strips, then a full-table miss, a hit and another miss.
      set_strip_length(6'd2);
      for (int i = 0; i < MAX_STRIPS; i++) begin
         queue_unit(UNIT_W'(i), i == 0);
         queue_unit(8'h5A, 1'b0);
      end
      queue_unit(8'h00, 1'b0);
      queue_unit(8'h00, 1'b0);
      queue_unit(8'h07, 1'b0);
      queue_unit(8'h5A, 1'b0);
      queue_unit(8'hFF, 1'b0);
      queue_unit(8'hFF, 1'b0);

      // Random phases over lengths and flow patterns; the first one backs the block up.
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         grow = strip_span(LEN_W'(phase_len[p])) > strip_span(dict_len);
         set_strip_length(LEN_W'(phase_len[p]));
         flow_mode = flow_mode_type'(p % 4);
         if (p == 0) long_hold_armed = 1'b1;
         queue_random_units(PHASE_UNITS, grow);
      end

      wait_until_idle();
      $display("Covered %0d source units and %0d strip results:", units_in, results_seen);
      $display("%0d new, %0d hits, %0d full misses; lengths zero through oversize, %0d phases.",
               fresh_seen, results_seen - fresh_seen - full_seen, full_seen, RANDOM_PHASES);
      if (fault_count == 0 && expected_labels.size() == 0) begin
         $display("PASS strip_dedup_labeler_unit");
      end else begin
         $display("FAIL strip_dedup_labeler_unit");
      end
      $finish;
   end

endmodule

### strip_dedup_labeler_unit.f
+incdir+sv
sv/sdl_pkg.sv
sv/sdl_match_cell.sv
sv/sdl_match_chain.sv
sv/sdl_dict_store.sv
sv/strip_dedup_labeler_unit.sv
sv/sdl_checker.sv
tb/sv/strip_dedup_labeler_unit_tb.sv
